### rtl/core/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// shared constants, command codes and sequencer states of the rational
// arithmetic unit
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int OPERAND_BITS_DEF = 16;
    localparam int CMD_BITS         = 3;
    localparam int NUM_BITS         = 33;
    localparam int DEN_BITS         = 31;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_NORM = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SIGN,
        S_GCD,
        S_DIV,
        S_DONE
    } back_state_t;

endpackage

### rtl/core/rar_in_if.sv
// ----------------------------------------------------------------------------
// rar_in_if
// request channel: command and two signed fractions
// ----------------------------------------------------------------------------
interface rar_in_if #(
    parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [rar_pkg::CMD_BITS-1:0]   cmd;
    logic signed [OPERAND_BITS-1:0] a_num;
    logic signed [OPERAND_BITS-1:0] a_den;
    logic signed [OPERAND_BITS-1:0] b_num;
    logic signed [OPERAND_BITS-1:0] b_den;

    modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

### rtl/core/rar_out_if.sv
// ----------------------------------------------------------------------------
// rar_out_if
// result channel: reduced fraction and zero denominator flag
// ----------------------------------------------------------------------------
interface rar_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rar_pkg::NUM_BITS-1:0] res_num;
    logic [rar_pkg::DEN_BITS-1:0]      res_den;
    logic                              zero_den;

    modport source (output valid, res_num, res_den, zero_den, input ready);
    modport sink   (input valid, res_num, res_den, zero_den, output ready);
endinterface

### rtl/core/rar_front.sv
// ----------------------------------------------------------------------------
// rar_front
// classifies a request into three multiplier operand pairs, an add or
// subtract flag, a unit denominator flag and the zero denominator flag
// ----------------------------------------------------------------------------
module rar_front #(
    parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF,
    parameter int ITEM_BITS    = 6 * OPERAND_BITS + 3
) (
    rar_in_if.sink               req,
    output logic                 push_valid,
    input  logic                 push_ready,
    output logic [ITEM_BITS-1:0] push_data
);
    import rar_pkg::*;

    localparam int N = OPERAND_BITS;

    logic signed [N-1:0] one_c;
    logic signed [N-1:0] ad, bd;
    logic signed [N-1:0] x0, y0, x1, y1, x2, y2;
    logic                sub, flag, unit;
    logic                a_zero, b_zero, bn_zero;

    assign one_c   = N'(1);
    assign a_zero  = (req.a_den == '0);
    assign b_zero  = (req.b_den == '0);
    assign bn_zero = (req.b_num == '0);
    assign ad      = a_zero ? one_c : req.a_den;
    assign bd      = b_zero ? one_c : req.b_den;

    always_comb
    begin
        x0   = req.a_num;
        y0   = one_c;
        x1   = '0;
        y1   = '0;
        x2   = ad;
        y2   = one_c;
        sub  = 1'b0;
        unit = 1'b0;
        flag = a_zero;
        unique case (req.cmd)
            CMD_ADD, CMD_SUB:
            begin
                y0   = bd;
                x1   = req.b_num;
                y1   = ad;
                y2   = bd;
                sub  = (req.cmd == CMD_SUB);
                flag = a_zero | b_zero;
            end
            CMD_MUL:
            begin
                y0   = req.b_num;
                y2   = bd;
                flag = a_zero | b_zero;
            end
            CMD_DIV:
            begin
                // dividing by zero gives the reduced numerator of a over one
                y0   = bn_zero ? one_c : bd;
                y2   = bn_zero ? one_c : req.b_num;
                unit = bn_zero;
                flag = a_zero | b_zero | bn_zero;
            end
            default:
            begin
                // normalise a alone
            end
        endcase
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;
    assign push_data  = {unit, sub, flag, x0, y0, x1, y1, x2, y2};

endmodule

### rtl/core/rar_queue.sv
// ----------------------------------------------------------------------------
// rar_queue
// small register queue between the front and the arithmetic sequencer
// ----------------------------------------------------------------------------
module rar_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import rar_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_valid & rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/rar_back.sv
// ----------------------------------------------------------------------------
// rar_back
// sequencer: three products on one multiplier, sign split, binary gcd,
// two restoring dividers and the result register
// ----------------------------------------------------------------------------
module rar_back #(
    parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF,
    parameter int ITEM_BITS    = 6 * OPERAND_BITS + 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [ITEM_BITS-1:0] q_data,
    rar_out_if.source            rsp
);
    import rar_pkg::*;

    localparam int N  = OPERAND_BITS;
    localparam int W  = 2 * OPERAND_BITS;
    localparam int KW = $clog2(W + 1);
    localparam int CW = $clog2(W);

    back_state_t             st_reg, st_next;
    logic [ITEM_BITS-1:0]    item_reg, item_next;
    logic signed [W-1:0]     p0_reg, p0_next, p1_reg, p1_next, d_reg, d_next;
    logic [W-1:0]            x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic [KW-1:0]           k_reg, k_next;
    logic [W-1:0]            qn_reg, qn_next, qd_reg, qd_next;
    logic [W-1:0]            rn_reg, rn_next, rd_reg, rd_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [NUM_BITS-1:0] out_num_reg, out_num_next;
    logic [DEN_BITS-1:0]     out_den_reg, out_den_next;
    logic                    out_flag_reg, out_flag_next;

    logic                    it_unit, it_sub, it_flag;
    logic signed [N-1:0]     it_x0, it_y0, it_x1, it_y1, it_x2, it_y2;
    logic signed [N-1:0]     mx, my;
    logic signed [W-1:0]     prod;
    logic signed [W:0]       nsum, dext;
    logic [W-1:0]            un, ud;
    logic [W:0]              trial_n, trial_d;
    logic signed [W:0]       snum;

    assign {it_unit, it_sub, it_flag, it_x0, it_y0, it_x1, it_y1, it_x2, it_y2} = item_reg;

    // shared multiplier, operands chosen by the step
    always_comb
    begin
        unique case (st_reg)
            S_MUL1:
            begin
                mx = it_x1;
                my = it_y1;
            end
            S_MUL2:
            begin
                mx = it_x2;
                my = it_y2;
            end
            default:
            begin
                mx = it_x0;
                my = it_y0;
            end
        endcase
    end
    assign prod = mx * my;

    assign nsum = it_sub ? ((W + 1)'(p0_reg) - (W + 1)'(p1_reg))
                         : ((W + 1)'(p0_reg) + (W + 1)'(p1_reg));
    assign dext = (W + 1)'(d_reg);
    assign un   = nsum[W] ? W'(-nsum) : W'(nsum);
    assign ud   = dext[W] ? W'(-dext) : W'(dext);

    assign trial_n = {rn_reg, qn_reg[W-1]} - {1'b0, g_reg};
    assign trial_d = {rd_reg, qd_reg[W-1]} - {1'b0, g_reg};

    assign snum = neg_reg ? -$signed({1'b0, qn_reg}) : $signed({1'b0, qn_reg});

    always_comb
    begin
        st_next        = st_reg;
        item_next      = item_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        d_next         = d_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        g_next         = g_reg;
        k_next         = k_reg;
        qn_next        = qn_reg;
        qd_next        = qd_reg;
        rn_next        = rn_reg;
        rd_next        = rd_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_flag_next  = out_flag_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        q_ready        = 1'b0;

        unique case (st_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    item_next = q_data;
                    st_next   = S_MUL0;
                end
            end
            S_MUL0:
            begin
                p0_next = prod;
                st_next = S_MUL1;
            end
            S_MUL1:
            begin
                p1_next = prod;
                st_next = S_MUL2;
            end
            S_MUL2:
            begin
                d_next  = prod;
                st_next = S_SIGN;
            end
            S_SIGN:
            begin
                qn_next  = un;
                qd_next  = ud;
                x_next   = un;
                y_next   = ud;
                k_next   = '0;
                neg_next = nsum[W] ^ dext[W];
                if (un == '0)
                begin
                    qd_next  = W'(1);
                    neg_next = 1'b0;
                    st_next  = S_DONE;
                end
                else
                begin
                    st_next = S_GCD;
                end
            end
            S_GCD:
            begin
                priority if (x_reg == y_reg)
                begin
                    g_next   = W'(x_reg << k_reg);
                    rn_next  = '0;
                    rd_next  = '0;
                    cnt_next = '0;
                    st_next  = S_DIV;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_reg > y_reg)
                begin
                    x_next = (x_reg - y_reg) >> 1;
                end
                else
                begin
                    y_next = (y_reg - x_reg) >> 1;
                end
            end
            S_DIV:
            begin
                // one quotient bit per cycle for both parts
                if (!trial_n[W])
                begin
                    rn_next = trial_n[W-1:0];
                end
                else
                begin
                    rn_next = {rn_reg[W-2:0], qn_reg[W-1]};
                end
                if (!trial_d[W])
                begin
                    rd_next = trial_d[W-1:0];
                end
                else
                begin
                    rd_next = {rd_reg[W-2:0], qd_reg[W-1]};
                end
                qn_next  = {qn_reg[W-2:0], ~trial_n[W]};
                qd_next  = {qd_reg[W-2:0], ~trial_d[W]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    st_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_num_next   = NUM_BITS'(snum);
                    out_den_next   = it_unit ? DEN_BITS'(1) : DEN_BITS'(qd_reg);
                    out_flag_next  = it_flag;
                    out_valid_next = 1'b1;
                    st_next        = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        d_reg        <= d_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        g_reg        <= g_next;
        k_reg        <= k_next;
        qn_reg       <= qn_next;
        qd_reg       <= qd_next;
        rn_reg       <= rn_next;
        rd_reg       <= rd_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        out_num_reg  <= out_num_next;
        out_den_reg  <= out_den_next;
        out_flag_reg <= out_flag_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.res_num  = out_num_reg;
    assign rsp.res_den  = out_den_reg;
    assign rsp.zero_den = out_flag_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |-> (st_reg == S_IDLE))
        else $error("queue popped while sequencer busy");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_GCD) |-> (x_reg != '0 && y_reg != '0))
        else $error("gcd operand reached zero");

    a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DONE && out_valid_reg && !rsp.ready) |=> (st_reg == S_DONE))
        else $error("result left sequencer while output slot full");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DIV && cnt_reg == CW'(W - 1)) |=> (st_reg == S_DONE))
        else $error("divider did not finish");

endmodule

### rtl/core/rational_arith_reduce_top.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce_top
// exact add, subtract, multiply, divide or normalise of two signed fractions
// with the result reduced by its greatest common divisor
// ----------------------------------------------------------------------------
// req carries cmd and a_num/a_den, b_num/b_den; rsp carries the reduced
// res_num/res_den and zero_den. both use valid/ready, a request moves when
// both are high.
// the front classifies a request into three products and queues it in a
// two-entry queue; the back forms the products one after another on one
// multiplier, splits the sign, runs a binary gcd (one step a cycle, at most
// about 2*2*OPERAND_BITS steps), then divides both parts by the gcd with two
// restoring dividers.
// one request is in the back at a time; the queue takes up to two more.
// a finished result waits in the output register while rsp is stalled and
// the back holds the next one until the register frees.
// reset empties the queue and the output register and idles the sequencer.
// ----------------------------------------------------------------------------
module rational_arith_reduce_top #(
    parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rar_in_if.sink    req,
    rar_out_if.source rsp
);
    import rar_pkg::*;

    localparam int ITEM_BITS = 6 * OPERAND_BITS + 3;

    logic                 push_valid, push_ready;
    logic [ITEM_BITS-1:0] push_data;
    logic                 pop_valid, pop_ready;
    logic [ITEM_BITS-1:0] pop_data;

    rar_front #(
        .OPERAND_BITS (OPERAND_BITS),
        .ITEM_BITS    (ITEM_BITS)
    ) u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rar_queue #(
        .WIDTH (ITEM_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    rar_back #(
        .OPERAND_BITS (OPERAND_BITS),
        .ITEM_BITS    (ITEM_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_data  (pop_data),
        .rsp     (rsp)
    );

endmodule
